/* src/pcls_pkg.sv */
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types and constants of the per-channel latency statistics block.
// ----------------------------------------------------------------------------
package pcls_pkg;
  localparam int NUM_CPUS     = 64;
  localparam int LATENCY_BITS = 40;
  localparam int CPU_W        = 6;
  localparam int LAT_W        = 40;
  localparam int DIV_W        = 10;
  localparam int CNT_W        = 32;
  localparam int SUM_W        = 64;
  localparam int NUM_RECS     = 2 * NUM_CPUS;
  localparam int IDX_W        = $clog2(NUM_RECS);
  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(1000);

  typedef logic [DIV_W-1:0] divisor_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic             context_req;
    logic [LAT_W-1:0] latency;
  } sample_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu_out;
    logic             context_out;
    logic [CNT_W-1:0] sample_count;
    logic [LAT_W-1:0] current_scaled;
    logic [LAT_W-1:0] minimum_scaled;
    logic [LAT_W-1:0] mean_scaled;
    logic [LAT_W-1:0] maximum_scaled;
  } stats_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic [LATENCY_BITS-1:0] current;
    logic [LATENCY_BITS-1:0] minimum;
    logic [SUM_W-1:0]        sum;
    logic [LATENCY_BITS-1:0] maximum;
  } rec_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_MEAN, ST_SCALE, ST_OUT
  } state_t;
endpackage

/* src/pcls_if.sv */
// ----------------------------------------------------------------------------
// pcls_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface pcls_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/per_channel_latency_stats_unit.sv */
// ----------------------------------------------------------------------------
// per_channel_latency_stats_unit
// Keeps count, current, minimum, sum and maximum per CPU and context and
// reports them scaled by the output divisor.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   in_ch     sink       cpu, context_req, latency
//   out_ch    source     cpu_out, context_out, sample_count, four scaled values
//   cfg_ch    sink       divisor for the reported values
//
// After reset a clearing pass initializes all 128 records of the record memory.
// An item goes from acceptance to its result through a memory read, an
// update and write back, a division of the sum by the count for the mean,
// then four divisions by the divisor on the same iterative divider, and a
// load of the output register. The next item is taken while the result
// waits there; a new result stalls only until the previous one leaves.
// Items with a CPU index out of range are dropped without a result.
module per_channel_latency_stats_unit (
  input  logic clk,
  input  logic rst,
  pcls_if.sink   in_ch,
  pcls_if.source out_ch,
  pcls_if.sink   cfg_ch
);
  import pcls_pkg::*;

  rec_t             mem [NUM_RECS];
  rec_t             rd_rec;
  rec_t             upd;
  rec_t             rec;
  state_t           state, state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] clr_idx;
  logic [CPU_W-1:0] cpu_r;
  logic             ctx_r;
  logic [LATENCY_BITS-1:0] lat_r;
  logic [DIV_W-1:0] divisor;
  logic [1:0]       step;
  logic [LAT_W-1:0] res [4];
  logic [SUM_W-1:0] mean;
  logic             out_valid;
  stats_t           out_data;
  logic             out_load;
  logic             d_start, d_done;
  logic [SUM_W-1:0] d_dividend, d_q;
  logic [CNT_W-1:0] d_divisor;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  rec_t             mem_wd;
  logic [SUM_W-1:0] sum_add;
  logic             sum_ovf;
  logic [1:0]       scale_sel;
  logic [SUM_W-1:0] scale_src;
  logic [CNT_W-1:0] scale_div;

  assign in_ch.ready  = (state == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state == ST_OUT) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) divisor <= DIV_RESET;
    else if (cfg_ch.valid && cfg_ch.ready) divisor <= cfg_ch.data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_rec <= mem[idx];
  end

  // Record update from the registered read.
  always_comb begin
    {sum_ovf, sum_add} = {1'b0, rd_rec.sum} + {{(SUM_W+1-LATENCY_BITS){1'b0}}, lat_r};
    upd         = rd_rec;
    upd.count   = (rd_rec.count == '1) ? rd_rec.count : rd_rec.count + CNT_W'(1);
    upd.current = lat_r;
    if (lat_r < rd_rec.minimum) upd.minimum = lat_r;
    upd.sum     = sum_ovf ? '1 : sum_add;
    if (lat_r > rd_rec.maximum) upd.maximum = lat_r;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = upd;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = '{count: '0, current: '0, minimum: '1, sum: '0, maximum: '0};
    end else if (state == ST_UPDATE) begin
      mem_we = 1'b1;
    end
  end

  // Dividend of the next scaling division: the one after the current step.
  assign scale_sel = (state == ST_SCALE) ? step + 2'd1 : 2'd0;
  assign scale_div = CNT_W'((divisor == '0) ? DIV_W'(1) : divisor);

  always_comb begin
    case (scale_sel)
      2'd0:    scale_src = SUM_W'(rec.current);
      2'd1:    scale_src = SUM_W'(rec.minimum);
      2'd2:    scale_src = mean;
      default: scale_src = SUM_W'(rec.maximum);
    endcase
  end

  pcls_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(d_divisor), .done(d_done), .quotient(d_q)
  );

  always_comb begin
    state_next = state;
    d_start    = 1'b0;
    d_dividend = upd.sum;
    d_divisor  = upd.count;
    unique case (state)
      ST_CLEAR:  if (clr_idx == IDX_W'(NUM_RECS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_ch.valid && in_ch.ready &&
                     32'(in_ch.data.cpu) < NUM_CPUS) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        d_start    = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        if (d_done) begin
          d_start    = 1'b1;
          d_dividend = scale_src;
          d_divisor  = scale_div;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (d_done) begin
          if (step == 2'd3) begin
            state_next = ST_OUT;
          end else begin
            d_start    = 1'b1;
            d_dividend = scale_src;
            d_divisor  = scale_div;
          end
        end
      end
      ST_OUT:    if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + IDX_W'(1);
      if (state == ST_MEAN) step <= '0;
      else if (state == ST_SCALE && d_done) step <= step + 2'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cpu_r <= in_ch.data.cpu;
      ctx_r <= in_ch.data.context_req;
      lat_r <= LATENCY_BITS'(in_ch.data.latency);
      idx   <= {in_ch.data.cpu, in_ch.data.context_req};
    end
    if (state == ST_UPDATE) rec <= upd;
    if (state == ST_MEAN && d_done) mean <= d_q;
    if (state == ST_SCALE && d_done) res[step] <= LAT_W'(d_q);
    if (out_load) begin
      out_data.cpu_out        <= cpu_r;
      out_data.context_out    <= ctx_r;
      out_data.sample_count   <= rec.count;
      out_data.current_scaled <= res[0];
      out_data.minimum_scaled <= res[1];
      out_data.mean_scaled    <= res[2];
      out_data.maximum_scaled <= res[3];
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
endmodule

/* src/pcls_div.sv */
// ----------------------------------------------------------------------------
// pcls_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pcls_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [pcls_pkg::SUM_W-1:0] dividend,
  input  logic [pcls_pkg::CNT_W-1:0] divisor,
  output logic                 done,
  output logic [pcls_pkg::SUM_W-1:0] quotient
);
  import pcls_pkg::*;

  logic [SUM_W-1:0] quo;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] dvs;
  logic [6:0]       cnt;
  logic             busy;
  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;

  assign shifted  = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[CNT_W]) begin
        rem <= diff;
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed latency samples into the per-channel statistics
// unit under several output divisors, and checks every result against a
// predictor that keeps its own copy of the record memory.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcls_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  class stats_scoreboard;
    logic [CNT_W-1:0] counts [NUM_RECS];
    logic [LAT_W-1:0] currents [NUM_RECS];
    logic [LAT_W-1:0] minimums [NUM_RECS];
    logic [SUM_W-1:0] sums [NUM_RECS];
    logic [LAT_W-1:0] maximums [NUM_RECS];
    divisor_t divisor;
    stats_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < NUM_RECS; i++) begin
        counts[i] = '0;
        currents[i] = '0;
        minimums[i] = '1;
        sums[i] = '0;
        maximums[i] = '0;
      end
      divisor = DIV_RESET;
      errors = 0;
    endfunction

    function void note_sample(sample_t s);
      int idx;
      logic [SUM_W-1:0] div;
      logic [SUM_W-1:0] mean;
      stats_t r;
      if (int'(s.cpu) >= NUM_CPUS) return;
      idx = int'(s.cpu) * 2 + int'(s.context_req);
      div = (divisor == '0) ? 64'd1 : 64'(divisor);
      if (counts[idx] != '1) counts[idx] = counts[idx] + 1;
      currents[idx] = s.latency;
      if (s.latency < minimums[idx]) minimums[idx] = s.latency;
      if (sums[idx] > ~64'd0 - 64'(s.latency)) sums[idx] = '1;
      else sums[idx] = sums[idx] + 64'(s.latency);
      if (s.latency > maximums[idx]) maximums[idx] = s.latency;
      mean = sums[idx] / 64'(counts[idx]);
      r.cpu_out = s.cpu;
      r.context_out = s.context_req;
      r.sample_count = counts[idx];
      r.current_scaled = LAT_W'(64'(currents[idx]) / div);
      r.minimum_scaled = LAT_W'(64'(minimums[idx]) / div);
      r.mean_scaled = LAT_W'(mean / div);
      r.maximum_scaled = LAT_W'(64'(maximums[idx]) / div);
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(stats_t got);
      stats_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.sample_count), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.cpu_out !== want.cpu_out)
        report_mismatch("cpu_out", 64'(got.cpu_out), 64'(want.cpu_out));
      if (got.context_out !== want.context_out)
        report_mismatch("context_out", 64'(got.context_out), 64'(want.context_out));
      if (got.sample_count !== want.sample_count)
        report_mismatch("sample_count", 64'(got.sample_count), 64'(want.sample_count));
      if (got.current_scaled !== want.current_scaled)
        report_mismatch("current_scaled", 64'(got.current_scaled),
                        64'(want.current_scaled));
      if (got.minimum_scaled !== want.minimum_scaled)
        report_mismatch("minimum_scaled", 64'(got.minimum_scaled),
                        64'(want.minimum_scaled));
      if (got.mean_scaled !== want.mean_scaled)
        report_mismatch("mean_scaled", 64'(got.mean_scaled), 64'(want.mean_scaled));
      if (got.maximum_scaled !== want.maximum_scaled)
        report_mismatch("maximum_scaled", 64'(got.maximum_scaled),
                        64'(want.maximum_scaled));
    endtask
  endclass

  logic clk;
  logic rst;

  pcls_if #(.payload_t(sample_t)) in_if ();
  pcls_if #(.payload_t(stats_t)) out_if ();
  pcls_if #(.payload_t(divisor_t)) cfg_if ();

  per_channel_latency_stats_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  stats_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_phase = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver alternates between always-ready stretches and random stalls.
  always @(negedge clk) begin
    ready_phase <= (ready_phase + 1) % 3000;
    if (ready_phase < 800) out_if.ready <= 1'b1;
    else if (ready_phase < 2000) out_if.ready <= ($urandom_range(0, 3) == 0);
    else out_if.ready <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task send_sample(logic [CPU_W-1:0] cpu, logic ctx, logic [LAT_W-1:0] lat);
    sample_t s;
    s.cpu = cpu;
    s.context_req = ctx;
    s.latency = lat;
    in_if.valid <= 1'b1;
    in_if.data <= s;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 400)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    end
  endtask

  task write_divisor(divisor_t value);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.divisor = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [LAT_W-1:0] pick_latency();
    case ($urandom_range(0, 3))
      0: return LAT_W'($urandom_range(0, 3000));
      1: return LAT_W'($urandom);
      2: return LAT_W'({$urandom, $urandom});
      default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endcase
  endfunction

  task random_phase(int n);
    for (int i = 0; i < n; i++) begin
      // Most samples land on a few records so the statistics build up.
      if ($urandom_range(0, 3) != 0)
        send_sample(CPU_W'($urandom_range(0, 3) * 21), 1'($urandom_range(0, 1)),
                    pick_latency());
      else
        send_sample(CPU_W'($urandom), 1'($urandom_range(0, 1)), pick_latency());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples, divisors reset/0/1/max: field extremes, min/max movement.
    send_sample('0, 1'b0, '0);
    send_sample('0, 1'b0, '1);
    send_sample('0, 1'b0, LAT_W'(999));
    send_sample('1, 1'b1, '1);
    send_sample('1, 1'b1, LAT_W'(1000));
    send_sample('1, 1'b0, LAT_W'(1));
    send_sample(CPU_W'(42), 1'b1, 40'h55_5555_5555);
    send_sample(CPU_W'(21), 1'b0, 40'hAA_AAAA_AAAA);
    write_divisor('0);
    send_sample('0, 1'b0, LAT_W'(7));
    send_sample('1, 1'b1, LAT_W'(0));
    send_sample(CPU_W'(42), 1'b1, '1);
    write_divisor(divisor_t'(1));
    send_sample('0, 1'b1, '1);
    send_sample('0, 1'b1, LAT_W'(3));
    send_sample(CPU_W'(21), 1'b0, LAT_W'(12345));
    write_divisor('1);
    send_sample('1, 1'b0, '1);
    send_sample('0, 1'b0, LAT_W'(1022));
    send_sample('0, 1'b0, LAT_W'(1023));

    write_divisor(DIV_RESET);
    random_phase(220);
    write_divisor(divisor_t'(1));
    random_phase(200);
    write_divisor('0);
    random_phase(200);
    write_divisor('1);
    random_phase(200);
    write_divisor(divisor_t'($urandom_range(2, 999)));
    random_phase(210);

    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
